/* rtl/core/bdf_pkg.sv */
// Shared types and constants for the brace-depth message framer.
// Used by every module of the framer core; depends on nothing.
package bdf_pkg;

  // Default sizes handed down from the top level
  localparam int STORE_DEPTH_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int IDX_W      = 10;
  localparam int MSG_W      = 32;
  localparam int NEST_W     = 11;
  localparam int BYTE_W     = 8;
  localparam int CMD_ADDR_W = 16;

  // Characters and limits
  localparam logic [BYTE_W-1:0] OPEN_BRACE  = 8'h7B;
  localparam logic [BYTE_W-1:0] CLOSE_BRACE = 8'h7D;
  localparam logic [NEST_W-1:0] NEST_MAX    = 11'd2047;

  // Input item kinds
  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Result event codes
  localparam logic [1:0] EV_COMPLETE = 2'd0;
  localparam logic [1:0] EV_OVERFLOW = 2'd1;
  localparam logic [1:0] EV_READ     = 2'd2;

  typedef enum logic {
    FR_HUNT,
    FR_COLLECT
  } fr_state_t;

  typedef struct packed {
    logic             kind;
    logic [BYTE_W-1:0] rx_byte;
    logic             chunk_end;
    logic [IDX_W-1:0] read_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        event_res;
    logic [IDX_W-1:0]  closing_index;
    logic [MSG_W-1:0]  message_number;
    logic [BYTE_W-1:0] read_data;
  } out_item_t;

  // Store operation passed from the front end to the back end
  typedef struct packed {
    logic                  is_read;
    logic                  has_result;
    logic [CMD_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]     wdata;
    logic                  rd_in_range;
    logic [1:0]            event_res;
    logic [IDX_W-1:0]      closing_index;
    logic [MSG_W-1:0]      message_number;
  } cmd_t;

  // Framer status seen by the top level checks
  typedef struct packed {
    logic collecting;
    logic depth_zero;
    logic index_zero;
  } fr_status_t;

endpackage

/* rtl/core/bdf_front.sv */
// Front end of the framer: accepts items, tracks framing state, and issues
// store operations into the command queue. Depends on bdf_pkg.
module bdf_front #(
  parameter int STORE_DEPTH = bdf_pkg::STORE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bdf_pkg::in_item_t    in_item,
  input  logic                 q_full,
  output logic                 q_push,
  output bdf_pkg::cmd_t        q_cmd,
  output bdf_pkg::fr_status_t  status
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);

  bdf_pkg::fr_state_t               state_r, state_nxt;
  logic [bdf_pkg::NEST_W-1:0]       depth_r, depth_nxt;
  logic [AW-1:0]                    idx_r, idx_nxt;
  logic [bdf_pkg::MSG_W-1:0]        count_r, count_nxt;

  logic                             accept;
  logic                             is_rx;
  logic                             is_open;
  logic                             is_close;
  logic [bdf_pkg::NEST_W-1:0]       depth_closed;
  logic                             close_done;
  logic                             at_last;
  logic                             in_range;

  // Classify the incoming item
  assign in_stall     = q_full;
  assign accept       = in_valid && !q_full;
  assign is_rx        = (in_item.kind == bdf_pkg::KIND_RX);
  assign is_open      = (in_item.rx_byte == bdf_pkg::OPEN_BRACE);
  assign is_close     = (in_item.rx_byte == bdf_pkg::CLOSE_BRACE);
  assign depth_closed = (depth_r != '0) ? depth_r - 1'b1 : '0;
  assign close_done   = is_close && (depth_closed == '0);
  assign at_last      = (idx_r == LAST_IDX);
  assign in_range     = ({{(32 - bdf_pkg::IDX_W){1'b0}}, in_item.read_offset}
                         < 32'(STORE_DEPTH));

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (accept && is_rx) begin
      case (state_r)
        bdf_pkg::FR_HUNT: begin
          if (is_open && !in_item.chunk_end) state_nxt = bdf_pkg::FR_COLLECT;
        end
        bdf_pkg::FR_COLLECT: begin
          if (close_done || at_last || in_item.chunk_end) state_nxt = bdf_pkg::FR_HUNT;
        end
        default: state_nxt = bdf_pkg::FR_HUNT;
      endcase
    end
  end

  // Datapath updates and store commands
  always_comb begin
    depth_nxt = depth_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    q_push    = 1'b0;
    q_cmd     = '0;
    if (accept) begin
      if (!is_rx) begin
        q_push            = 1'b1;
        q_cmd.is_read     = 1'b1;
        q_cmd.has_result  = 1'b1;
        q_cmd.addr        = bdf_pkg::CMD_ADDR_W'(in_item.read_offset);
        q_cmd.rd_in_range = in_range;
        q_cmd.event_res   = bdf_pkg::EV_READ;
      end else begin
        case (state_r)
          bdf_pkg::FR_HUNT: begin
            if (is_open) begin
              q_push      = 1'b1;
              q_cmd.addr  = '0;
              q_cmd.wdata = in_item.rx_byte;
              if (!in_item.chunk_end) begin
                depth_nxt = bdf_pkg::NEST_W'(1);
                idx_nxt   = AW'(1);
              end
            end
          end
          bdf_pkg::FR_COLLECT: begin
            q_push      = 1'b1;
            q_cmd.addr  = bdf_pkg::CMD_ADDR_W'(idx_r);
            q_cmd.wdata = in_item.rx_byte;
            if (close_done) begin
              // Frame complete: report and go back to hunting
              q_cmd.has_result     = 1'b1;
              q_cmd.event_res      = bdf_pkg::EV_COMPLETE;
              q_cmd.closing_index  = bdf_pkg::IDX_W'(idx_r);
              q_cmd.message_number = count_r;
              count_nxt            = count_r + 1'b1;
              depth_nxt            = '0;
              idx_nxt              = '0;
            end else if (at_last) begin
              // Store full: drop the frame
              q_cmd.has_result = 1'b1;
              q_cmd.event_res  = bdf_pkg::EV_OVERFLOW;
              depth_nxt        = '0;
              idx_nxt          = '0;
            end else if (in_item.chunk_end) begin
              depth_nxt = '0;
              idx_nxt   = '0;
            end else begin
              idx_nxt = idx_r + 1'b1;
              if (is_close) begin
                depth_nxt = depth_closed;
              end else if (is_open && depth_r != bdf_pkg::NEST_MAX) begin
                depth_nxt = depth_r + 1'b1;
              end
            end
          end
          default: begin
            depth_nxt = '0;
            idx_nxt   = '0;
          end
        endcase
      end
    end
  end

  // Framing state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdf_pkg::FR_HUNT;
      depth_r <= '0;
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

  assign status.collecting = (state_r == bdf_pkg::FR_COLLECT);
  assign status.depth_zero = (depth_r == '0);
  assign status.index_zero = (idx_r == '0);

endmodule

/* rtl/core/bdf_cmd_queue.sv */
// Short command queue between the framer front end and the store back end.
// Holds cmd_t entries from bdf_pkg in flip-flops.
module bdf_cmd_queue #(
  parameter int DEPTH = bdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bdf_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output bdf_pkg::cmd_t pop_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  bdf_pkg::cmd_t  entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop_en;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];
  assign pop_en    = pop && pop_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop_en) rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop_en) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

/* rtl/core/bdf_back.sv */
// Back end of the framer: executes store writes and reads in order and
// drives the result register. Depends on bdf_pkg.
module bdf_back #(
  parameter int STORE_DEPTH = bdf_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  bdf_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bdf_pkg::out_item_t out_item
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [bdf_pkg::BYTE_W-1:0] frame_store [STORE_DEPTH];

  logic                       s1_valid_r, s1_valid_nxt;
  bdf_pkg::cmd_t              s1_cmd_r;
  logic [bdf_pkg::BYTE_W-1:0] rd_data_r;
  logic                       out_valid_r, out_valid_nxt;
  bdf_pkg::out_item_t         out_item_r, out_item_nxt;

  logic                       out_free;
  logic                       s1_free;
  logic                       s1_move;
  logic [AW-1:0]              addr;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || out_free;
  assign q_pop    = q_valid && (s1_free || !q_cmd.has_result);
  assign addr     = q_cmd.addr[AW-1:0];

  // Store access: write or registered read on each popped command
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_cmd.is_read) rd_data_r <= frame_store[addr];
      else frame_store[addr] <= q_cmd.wdata;
    end
  end

  // Track the access stage and the result register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (q_pop && q_cmd.has_result) s1_valid_nxt = 1'b1;
    else if (s1_move) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

    out_item_nxt.event_res      = s1_cmd_r.event_res;
    out_item_nxt.closing_index  = s1_cmd_r.closing_index;
    out_item_nxt.message_number = s1_cmd_r.message_number;
    out_item_nxt.read_data      = (s1_cmd_r.is_read && s1_cmd_r.rd_in_range) ?
                                  rd_data_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on transfer
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.has_result) s1_cmd_r <= q_cmd;
    if (s1_move) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/brace_depth_message_framer_core.sv */
// Brace-depth message framer core: front end, command queue, store back end.
// An item's result passes the command queue, access stage and result register.
// Throughput: one item per cycle when not stalled; set by the back end's single store port.
// Reset (rst_n, synchronous): hunting, depth/index/message count zero, queue
// and result registers empty; store contents stay undefined, no clearing pass.
module brace_depth_message_framer_core #(
  parameter int STORE_DEPTH = bdf_pkg::STORE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = bdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bdf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bdf_pkg::out_item_t out_item
);

  logic                q_push;
  bdf_pkg::cmd_t       q_push_cmd;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  bdf_pkg::cmd_t       q_pop_cmd;
  bdf_pkg::fr_status_t fr_status;

  bdf_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd),
    .status   (fr_status)
  );

  bdf_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_pop_cmd)
  );

  bdf_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Hunting leaves no frame state behind
  a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !fr_status.collecting |-> fr_status.depth_zero && fr_status.index_zero)
    else $error("framer hunting with nonzero depth or index");

  // A frame in progress has its opening brace stored and open
  a_collect_live: assert property (@(posedge clk) disable iff (!rst_n)
    fr_status.collecting |-> !fr_status.depth_zero && !fr_status.index_zero)
    else $error("framer collecting with zero depth or index");

  // Never write into a full command queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // Only defined event codes leave the block
  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.event_res == bdf_pkg::EV_COMPLETE ||
                   out_item.event_res == bdf_pkg::EV_OVERFLOW ||
                   out_item.event_res == bdf_pkg::EV_READ))
    else $error("undefined event code on result");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for brace_depth_message_framer_core.
// Depends on bdf_pkg and the framer core RTL. A scoreboard class predicts
// the result of every transfer; plain tasks drive framed, broken and noisy traffic.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH       = bdf_pkg::STORE_DEPTH_DEF;
  localparam int RAND_ITEMS  = 350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  // Predicts framer results and checks the ones the core returns
  class framer_scoreboard;
    logic [bdf_pkg::BYTE_W-1:0] store_img [DEPTH];
    int                         last_written;
    bit                         collecting;
    logic [bdf_pkg::NEST_W-1:0] depth;
    int unsigned                wr_idx;
    logic [bdf_pkg::MSG_W-1:0]  msg_count;
    bdf_pkg::out_item_t         pending_results[$];
    int unsigned                fail_count;
    int unsigned                n_complete;
    int unsigned                n_overflow;
    int unsigned                n_read;

    function new();
      last_written = -1;
      msg_count    = '0;
      fail_count   = 0;
      n_complete   = 0;
      n_overflow   = 0;
      n_read       = 0;
      drop_frame();
    endfunction

    function void drop_frame();
      collecting = 1'b0;
      depth      = '0;
      wr_idx     = 0;
    endfunction

    function void store_byte(int unsigned idx, logic [bdf_pkg::BYTE_W-1:0] b);
      store_img[idx] = b;
      if (int'(idx) > last_written) last_written = int'(idx);
    endfunction

    // Work out the result, if any, of one accepted input transfer
    function void note_transfer(bdf_pkg::in_item_t it);
      bdf_pkg::out_item_t res;
      int unsigned        idx;
      res = '0;
      if (it.kind == bdf_pkg::KIND_READ) begin
        res.event_res = bdf_pkg::EV_READ;
        if (it.read_offset < DEPTH) res.read_data = store_img[it.read_offset];
        pending_results.push_back(res);
        return;
      end
      if (!collecting) begin
        // Hunt: only an opening brace starts a frame
        if (it.rx_byte == bdf_pkg::OPEN_BRACE) begin
          store_byte(0, it.rx_byte);
          wr_idx     = 1;
          depth      = bdf_pkg::NEST_W'(1);
          collecting = 1'b1;
        end
      end else begin
        idx = wr_idx;
        if (idx >= DEPTH) idx = DEPTH - 1;
        store_byte(idx, it.rx_byte);
        if (it.rx_byte == bdf_pkg::CLOSE_BRACE) begin
          if (depth != '0) depth = depth - 1'b1;
          if (depth == '0) begin
            res.event_res      = bdf_pkg::EV_COMPLETE;
            res.closing_index  = bdf_pkg::IDX_W'(idx);
            res.message_number = msg_count;
            pending_results.push_back(res);
            msg_count = msg_count + 1'b1;
            drop_frame();
            return;
          end
        end else if (it.rx_byte == bdf_pkg::OPEN_BRACE) begin
          if (depth != bdf_pkg::NEST_MAX) depth = depth + 1'b1;
        end
        wr_idx = idx + 1;
        // Drop the frame once the store is full
        if (wr_idx >= DEPTH) begin
          res.event_res = bdf_pkg::EV_OVERFLOW;
          pending_results.push_back(res);
          drop_frame();
        end
      end
      if (it.chunk_end && collecting) drop_frame();
    endfunction

    function void check_field(string name, logic [bdf_pkg::MSG_W-1:0] want,
                              logic [bdf_pkg::MSG_W-1:0] got);
      if (want !== got) begin
        fail_count++;
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    endfunction

    // Compare one accepted result against the oldest prediction
    function void check_result(bdf_pkg::out_item_t got);
      bdf_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result transfer with nothing expected: event_res 0x%0h", got.event_res);
        return;
      end
      want = pending_results.pop_front();
      case (want.event_res)
        bdf_pkg::EV_COMPLETE: n_complete++;
        bdf_pkg::EV_OVERFLOW: n_overflow++;
        default:              n_read++;
      endcase
      check_field("event_res", bdf_pkg::MSG_W'(want.event_res),
                  bdf_pkg::MSG_W'(got.event_res));
      check_field("closing_index", bdf_pkg::MSG_W'(want.closing_index),
                  bdf_pkg::MSG_W'(got.closing_index));
      check_field("message_number", want.message_number, got.message_number);
      check_field("read_data", bdf_pkg::MSG_W'(want.read_data),
                  bdf_pkg::MSG_W'(got.read_data));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bdf_pkg::in_item_t   in_item;
  logic                out_valid;
  logic                out_stall;
  bdf_pkg::out_item_t  out_item;

  framer_scoreboard sb;
  bit          no_idle;
  int unsigned sent_items;
  int unsigned cycles;

  brace_depth_message_framer_core #(
    .STORE_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bound the run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles", cycles);
    $display("RESULT: ERROR");
    $finish;
  end

  // Stall the result side at random
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !no_idle && ($urandom_range(99) < 35);
    end
  end

  // Check every result transfer
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  // Drive one input transfer; entered and left at a falling edge
  task automatic send_item(input bdf_pkg::in_item_t it);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(it);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_rx(input logic [bdf_pkg::BYTE_W-1:0] b, input bit ce);
    bdf_pkg::in_item_t it;
    it.kind        = bdf_pkg::KIND_RX;
    it.rx_byte     = b;
    it.chunk_end   = ce;
    it.read_offset = bdf_pkg::IDX_W'($urandom_range(DEPTH - 1, 0));
    send_item(it);
  endtask

  task automatic send_read(input int unsigned offset);
    bdf_pkg::in_item_t it;
    it.kind        = bdf_pkg::KIND_READ;
    it.rx_byte     = bdf_pkg::BYTE_W'($urandom_range(255, 0));
    it.chunk_end   = 1'($urandom_range(1, 0));
    it.read_offset = bdf_pkg::IDX_W'(offset);
    send_item(it);
  endtask

  function automatic logic [bdf_pkg::BYTE_W-1:0] plain_byte();
    logic [bdf_pkg::BYTE_W-1:0] b;
    do b = bdf_pkg::BYTE_W'($urandom_range(255, 0));
    while (b == bdf_pkg::OPEN_BRACE || b == bdf_pkg::CLOSE_BRACE);
    return b;
  endfunction

  // Well-formed message with random nesting, closed back to depth zero
  task automatic send_message(input int body_len, input bit end_chunk);
    int d;
    int r;
    d = 1;
    send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
    for (int k = 0; k < body_len; k++) begin
      r = $urandom_range(99);
      if (r < 15) begin
        send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
        d++;
      end else if (r < 30 && d > 1) begin
        send_rx(bdf_pkg::CLOSE_BRACE, 1'b0);
        d--;
      end else begin
        send_rx(plain_byte(), 1'b0);
      end
    end
    while (d > 1) begin
      send_rx(bdf_pkg::CLOSE_BRACE, 1'b0);
      d--;
    end
    send_rx(bdf_pkg::CLOSE_BRACE, end_chunk);
  endtask

  // Frame that fills the whole store: completes on its last entry or overflows
  task automatic send_long_frame(input bit overflow);
    send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
    if (overflow) begin
      send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
      for (int k = 2; k < DEPTH - 1; k++)
        send_rx(($urandom_range(9) == 0) ? bdf_pkg::OPEN_BRACE : plain_byte(), 1'b0);
      // Closing brace on the last entry leaves depth above zero
      send_rx(bdf_pkg::CLOSE_BRACE, 1'b1);
    end else begin
      for (int k = 1; k < DEPTH - 1; k++) send_rx(plain_byte(), 1'b0);
      send_rx(bdf_pkg::CLOSE_BRACE, 1'b0);
    end
  endtask

  task automatic send_random_read();
    if (sb.last_written >= 0) send_read($urandom_range(sb.last_written, 0));
  endtask

  initial begin
    int unsigned rand_start;
    int          r;
    int          n;
    sb         = new();
    no_idle    = 1'b0;
    sent_items = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: noise, nesting, chunk-end drops, completion on a chunk end
    send_rx(8'h00, 1'b0);
    send_rx(8'hFF, 1'b0);
    send_rx(bdf_pkg::CLOSE_BRACE, 1'b0);
    send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
    send_rx(bdf_pkg::CLOSE_BRACE, 1'b0);
    send_read(0);
    send_read(1);
    send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
    send_rx(8'h61, 1'b0);
    send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
    send_rx(bdf_pkg::CLOSE_BRACE, 1'b0);
    send_rx(bdf_pkg::CLOSE_BRACE, 1'b0);
    send_read(4);
    send_rx(bdf_pkg::OPEN_BRACE, 1'b1);
    send_rx(bdf_pkg::CLOSE_BRACE, 1'b0);
    send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
    send_rx(8'h78, 1'b1);
    send_rx(bdf_pkg::CLOSE_BRACE, 1'b0);
    send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
    send_rx(bdf_pkg::CLOSE_BRACE, 1'b1);
    send_read(2);
    send_read(3);

    // Store-filling frame that overflows on its last entry
    send_long_frame(1'b1);
    send_read(DEPTH - 1);
    send_read(0);

    // Random traffic, mostly well-formed messages
    rand_start = sent_items;
    while (sent_items - rand_start < RAND_ITEMS) begin
      no_idle = (sent_items - rand_start >= 100) && (sent_items - rand_start < 250);
      r = $urandom_range(99);
      if (r < 55) begin
        send_message($urandom_range(20, 0), $urandom_range(3) == 0);
      end else if (r < 72) begin
        n = $urandom_range(3, 1);
        repeat (n) send_random_read();
      end else if (r < 82) begin
        n = $urandom_range(4, 1);
        repeat (n) send_rx(plain_byte(), 1'($urandom_range(1, 0)));
      end else if (r < 90) begin
        // Frame cut short by a chunk end, possibly on its own opening brace
        n = $urandom_range(6, 0);
        send_rx(bdf_pkg::OPEN_BRACE, n == 0);
        for (int k = 1; k <= n; k++) send_rx(plain_byte(), k == n);
      end else begin
        // Stray closing braces and lone opens that a chunk end drops
        send_rx(bdf_pkg::CLOSE_BRACE, 1'($urandom_range(1, 0)));
        send_rx(bdf_pkg::OPEN_BRACE, 1'b0);
        send_rx(bdf_pkg::OPEN_BRACE, 1'b1);
      end
    end
    no_idle  = 1'b0;
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d input transfers: %0d completed messages, %0d overflows, %0d reads.",
             sent_items, sb.n_complete, sb.n_overflow, sb.n_read);
    $display("Traffic mixed nesting, chunk-end drops, noise and a full-store frame.");
    if (sb.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches found", sb.fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
